// ===== src/hysteresis_pulse_peak_finder_core_macros.svh =====
// ----------------------------------------------------------------------------
// Hysteresis pulse peak finder - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef HYSTERESIS_PULSE_PEAK_FINDER_CORE_MACROS_SVH
`define HYSTERESIS_PULSE_PEAK_FINDER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define HPPF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("hppf assertion failed in same-cycle check");

// antecedent implies consequent in the following cycle
`define HPPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("hppf assertion failed in next-cycle check");

`endif

// ===== src/hppf_pkg.sv =====
// ----------------------------------------------------------------------------
// hppf_pkg
// Widths, register codes, reset values and the types that pass between the
// front stage and the pulse tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package hppf_pkg;

	// field widths
	localparam int SAMPLE_W = 16;
	localparam int BASE_W   = 20;
	localparam int NOISE_W  = 16;
	localparam int SIGMA_W  = 8;
	localparam int HMIN_W   = 20;
	localparam int VAL_W    = 21;   // baseline-corrected value, Q16.4 signed
	localparam int PROD_W   = SIGMA_W + NOISE_W;
	localparam int PT_W     = 10;
	localparam int PI_W     = 9;
	localparam int DEPTH_W  = 20;

	// stream widths
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 40;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_SIGMA  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_SIGMA = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_MIN  = 2'd2;
	localparam int CFG_DATA_W = 20;

	// register reset values (9.0 sigma, 100.0 counts)
	localparam logic [SIGMA_W-1:0] OPEN_SIGMA_RST  = 8'd144;
	localparam logic [SIGMA_W-1:0] CLOSE_SIGMA_RST = 8'd144;
	localparam logic [HMIN_W-1:0]  HEIGHT_MIN_RST  = 20'd1600;

	// one sample after the front stage
	typedef struct packed {
		logic                    first;
		logic                    enable;     // thresholds usable for a new waveform
		logic signed [VAL_W-1:0] value;
		logic signed [VAL_W-1:0] start_lvl;
		logic signed [VAL_W-1:0] end_lvl;
	} item_t;

	// one reported pulse
	typedef struct packed {
		logic [DEPTH_W-1:0] peak_depth;
		logic [PI_W-1:0]    pulse_num;
		logic [PT_W-1:0]    peak_pos;
	} result_t;

endpackage

`default_nettype wire

// ===== src/hppf_front.sv =====
// ----------------------------------------------------------------------------
// hppf_front
// Input register, baseline subtraction and threshold derivation. The levels
// are worked out for every sample but only used on the first of a waveform.
// ----------------------------------------------------------------------------
`default_nettype none

module hppf_front (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   advance,
	input  wire                                   in_valid,
	input  wire signed [hppf_pkg::SAMPLE_W-1:0]   in_sample,
	input  wire signed [hppf_pkg::BASE_W-1:0]     in_baseline,
	input  wire        [hppf_pkg::NOISE_W-1:0]    in_noise,
	input  wire                                   in_first,
	input  wire        [hppf_pkg::SIGMA_W-1:0]    open_sigma,
	input  wire        [hppf_pkg::SIGMA_W-1:0]    close_sigma,
	output logic                                  item_valid,
	output hppf_pkg::item_t                       item
);
	import hppf_pkg::*;

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic signed [BASE_W-1:0]   baseline_s1;
	logic [NOISE_W-1:0]         noise_s1;
	logic                       first_s1;
	logic signed [BASE_W-1:0]   base_q;

	logic [SIGMA_W-1:0]         hi_sigma;
	logic [SIGMA_W-1:0]         lo_sigma;
	logic [PROD_W-1:0]          prod_hi;
	logic [PROD_W-1:0]          prod_lo;
	logic [PROD_W:0]            prod_hi_up;
	logic [VAL_W-1:0]           mag_start;
	logic [VAL_W-1:0]           mag_end;
	logic signed [BASE_W-1:0]   base_eff;
	logic signed [VAL_W-1:0]    value;
	item_t                      item_d;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			sample_s1   <= in_sample;
			baseline_s1 <= in_baseline;
			noise_s1    <= in_noise;
			first_s1    <= in_first;
		end
	end

	// latched baseline of the current waveform
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (advance && valid_s1 && first_s1) begin
			base_q <= baseline_s1;
		end
	end

	// thresholds: larger sigma opens, smaller closes
	always_comb begin
		if (close_sigma > open_sigma) begin
			hi_sigma = close_sigma;
			lo_sigma = open_sigma;
		end else begin
			hi_sigma = open_sigma;
			lo_sigma = close_sigma;
		end
		prod_hi    = PROD_W'(hi_sigma) * PROD_W'(noise_s1);
		prod_lo    = PROD_W'(lo_sigma) * PROD_W'(noise_s1);
		// start rounds the magnitude up, end rounds it down
		prod_hi_up = {1'b0, prod_hi} + (PROD_W+1)'(15);
		mag_start  = VAL_W'(prod_hi_up[PROD_W:4]);
		mag_end    = VAL_W'(prod_lo[PROD_W-1:4]);
	end

	// baseline-corrected value in Q16.4
	always_comb begin
		base_eff = first_s1 ? baseline_s1 : base_q;
		value    = {sample_s1[SAMPLE_W-1], sample_s1, 4'b0000}
		         - {base_eff[BASE_W-1], base_eff};

		item_d.first     = first_s1;
		item_d.enable    = (noise_s1 != '0) && (lo_sigma != '0);
		item_d.value     = value;
		item_d.start_lvl = -$signed(mag_start);
		item_d.end_lvl   = -$signed(mag_end);
	end

	// stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (advance) begin
			item_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			item <= item_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/hppf_track.sv =====
// ----------------------------------------------------------------------------
// hppf_track
// Pulse state per waveform: hysteresis entry and exit, running minimum and
// its index, height check, pulse counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hppf_track #(
	parameter int MAX_SAMPLES = 1024
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              advance,
	input  wire                              item_valid,
	input  hppf_pkg::item_t                  item,
	input  wire [hppf_pkg::HMIN_W-1:0]       height_min,
	output logic                             out_valid,
	output hppf_pkg::result_t                out_data
);
	import hppf_pkg::*;

	localparam int IW = $clog2(MAX_SAMPLES);
	localparam logic [IW-1:0] IDX_LAST = IW'(MAX_SAMPLES - 1);

	logic                    in_pulse_q;
	logic                    enabled_q;
	logic signed [VAL_W-1:0] min_q;
	logic [IW-1:0]           min_idx_q;
	logic [IW-1:0]           sidx_q;
	logic [PI_W-1:0]         pcount_q;
	logic signed [VAL_W-1:0] start_lvl_q;
	logic signed [VAL_W-1:0] end_lvl_q;

	logic                    ip;
	logic                    en;
	logic signed [VAL_W-1:0] sl;
	logic signed [VAL_W-1:0] el;
	logic signed [VAL_W-1:0] mv;
	logic [IW-1:0]           mi;
	logic [IW-1:0]           idx;
	logic [PI_W-1:0]         pc;
	logic signed [VAL_W-1:0] cur_min;
	logic [IW-1:0]           cur_idx;
	logic [VAL_W-1:0]        depth;

	logic                    in_pulse_n;
	logic signed [VAL_W-1:0] min_n;
	logic [IW-1:0]           min_idx_n;
	logic [PI_W-1:0]         pcount_n;
	logic [IW-1:0]           sidx_n;
	logic                    fire;
	logic [IW-1:0]           peak_idx;
	logic [IW+PT_W-1:0]      peak_ext;

	// effective state: a first sample restarts the waveform
	always_comb begin
		ip  = item.first ? 1'b0 : in_pulse_q;
		en  = item.first ? item.enable : enabled_q;
		sl  = item.first ? item.start_lvl : start_lvl_q;
		el  = item.first ? item.end_lvl : end_lvl_q;
		mv  = item.first ? '0 : min_q;
		mi  = item.first ? '0 : min_idx_q;
		idx = item.first ? '0 : sidx_q;
		pc  = item.first ? '0 : pcount_q;
	end

	// hysteresis decision
	always_comb begin
		in_pulse_n = ip;
		min_n      = mv;
		min_idx_n  = mi;
		pcount_n   = pc;
		fire       = 1'b0;
		cur_min    = mv;
		cur_idx    = mi;
		if (item.value < mv) begin
			cur_min = item.value;
			cur_idx = idx;
		end
		depth = VAL_W'(-cur_min);
		if (en) begin
			if (!ip) begin
				if (item.value <= sl) begin
					in_pulse_n = 1'b1;
					min_n      = item.value;
					min_idx_n  = idx;
				end
			end else if (item.value >= el) begin
				// pulse closes; report only when deep enough
				if (depth > {1'b0, height_min}) begin
					fire     = 1'b1;
					pcount_n = pc + PI_W'(1);
				end
				in_pulse_n = 1'b0;
				min_n      = '0;
				min_idx_n  = '0;
			end else begin
				min_n     = cur_min;
				min_idx_n = cur_idx;
			end
		end
		sidx_n   = (idx < IDX_LAST) ? idx + IW'(1) : idx;
		peak_idx = cur_idx;
		peak_ext = {{PT_W{1'b0}}, peak_idx};
	end

	// waveform state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pulse_q  <= 1'b0;
			enabled_q   <= 1'b0;
			min_q       <= '0;
			min_idx_q   <= '0;
			sidx_q      <= '0;
			pcount_q    <= '0;
			start_lvl_q <= '0;
			end_lvl_q   <= '0;
		end else if (advance && item_valid) begin
			in_pulse_q  <= in_pulse_n;
			enabled_q   <= en;
			min_q       <= min_n;
			min_idx_q   <= min_idx_n;
			sidx_q      <= sidx_n;
			pcount_q    <= pcount_n;
			start_lvl_q <= sl;
			end_lvl_q   <= el;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= item_valid && fire;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_valid && fire) begin
			out_data.peak_pos   <= peak_ext[PT_W-1:0];
			out_data.pulse_num  <= pc;
			out_data.peak_depth <= depth[DEPTH_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== src/hysteresis_pulse_peak_finder_core.sv =====
// ----------------------------------------------------------------------------
// hysteresis_pulse_peak_finder_core
// Finds pulses below a per-waveform baseline with start/end hysteresis and
// reports the depth and position of each pulse minimum.
//
//   channel  dir  handshake          content
//   s_       in   s_tvalid/s_tready  sample, baseline, noise; tuser = first
//   m_       out  m_tvalid/m_tready  peak position, pulse number, peak_depth
//   cfg_     in   cfg_valid/ready    register index and write data
//
// One sample per cycle sustained while m_ is not held; a result passes the
// input, stage 2 and result registers before it is offered on m_. Reset
// clears all control state and the registers to 9.0, 9.0 and 100.0. The
// three stages move together: a held result stalls the input until the
// output request completes.
// ----------------------------------------------------------------------------
`default_nettype none

module hysteresis_pulse_peak_finder_core #(
	parameter int MAX_SAMPLES = 1024
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// sample [15:0], baseline [35:16], noise [51:36], zero pad [55:52]
	input  wire [hppf_pkg::IN_DATA_W-1:0]        s_tdata,
	// first [0]
	input  wire                                  s_tuser,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	// peak position [9:0], pulse number [18:10], peak_depth [38:19], zero pad [39]
	output logic [hppf_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire [hppf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [hppf_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import hppf_pkg::*;

	logic [SIGMA_W-1:0] open_sigma_q;
	logic [SIGMA_W-1:0] close_sigma_q;
	logic [HMIN_W-1:0]  height_min_q;
	logic               advance;
	logic               item_valid;
	item_t              item;
	result_t            res;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_sigma_q  <= OPEN_SIGMA_RST;
			close_sigma_q <= CLOSE_SIGMA_RST;
			height_min_q  <= HEIGHT_MIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_OPEN_SIGMA:  open_sigma_q  <= cfg_data[SIGMA_W-1:0];
				CFG_CLOSE_SIGMA: close_sigma_q <= cfg_data[SIGMA_W-1:0];
				CFG_HEIGHT_MIN:  height_min_q  <= cfg_data[HMIN_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipe moves when the result slot is free or being taken
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = advance;

	hppf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.in_valid    (s_tvalid),
		.in_sample   (s_tdata[15:0]),
		.in_baseline (s_tdata[35:16]),
		.in_noise    (s_tdata[51:36]),
		.in_first    (s_tuser),
		.open_sigma  (open_sigma_q),
		.close_sigma (close_sigma_q),
		.item_valid  (item_valid),
		.item        (item)
	);

	hppf_track #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item),
		.height_min (height_min_q),
		.out_valid  (m_tvalid),
		.out_data   (res)
	);

	// output packing
	assign m_tdata = {1'b0, res.peak_depth, res.pulse_num, res.peak_pos};

endmodule

`default_nettype wire

// ===== src/hppf_checker.sv =====
// ----------------------------------------------------------------------------
// hppf_checker
// Port-level checks on the peak finder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hysteresis_pulse_peak_finder_core_macros.svh"

module hppf_checker (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 s_tready,
	input wire [hppf_pkg::OUT_DATA_W-1:0]      m_tdata,
	input wire                                 m_tvalid,
	input wire                                 m_tready
);
	import hppf_pkg::*;

	logic out_held;
	logic depth_zero;

	assign out_held   = m_tvalid && !m_tready;
	assign depth_zero = (m_tdata[38:19] == '0);

	// a held result keeps its payload
	`HPPF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_held, m_tvalid && $stable(m_tdata))
	// a held result stalls the input side
	`HPPF_ASSERT_SAME(a_stall_back, clk, arst_n, out_held, !s_tready)
	// a reported depth is strictly above a non-negative minimum
	`HPPF_ASSERT_SAME(a_depth_nz, clk, arst_n, m_tvalid, !depth_zero)
	// a new result only appears after the pipe moved
	`HPPF_ASSERT_SAME(a_rise_moves, clk, arst_n, $rose(m_tvalid), $past(s_tready))

endmodule

bind hysteresis_pulse_peak_finder_core hppf_checker u_hppf_checker (.*);

`default_nettype wire
